// ===== src/s2d_pkg.sv =====
// ---------------------------------------------------------------------------
// s2d_pkg: shared types and constants for signed_int_to_decimal_ascii
// Widths, ASCII codes and the job types passed between the front end,
// the binary-to-decimal converter and the character emitter.
// ---------------------------------------------------------------------------
package s2d_pkg;

   localparam int VALUE_W       = 32;
   localparam int CHAR_W        = 8;
   localparam int DIGIT_W       = 4;
   localparam int DIGIT_CNT     = 10;
   localparam int DIGIT_IDX_W   = $clog2(DIGIT_CNT);
   localparam int BCD_W         = DIGIT_CNT * DIGIT_W;
   localparam int BITS_PER_STEP = 4;
   localparam int STEP_CNT      = VALUE_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(STEP_CNT);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
   } mag_job_type;

   typedef struct packed {
      logic                           neg;
      digit_type [DIGIT_CNT-1:0]      digits;
   } dec_job_type;

endpackage

// ===== src/s2d_front.sv =====
// ---------------------------------------------------------------------------
// s2d_front: input stage
// Accepts one integer per beat, splits it into sign and unsigned magnitude
// and holds it in a two-entry queue until the converter takes it.
// ---------------------------------------------------------------------------
module s2d_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic signed [s2d_pkg::VALUE_W-1:0] req_value,
   input  logic                             push,
   output logic                             full,
   output logic                             job_valid,
   output s2d_pkg::mag_job_type             job,
   input  logic                             job_take
);

   s2d_pkg::mag_job_type                  q_ff [s2d_pkg::QUEUE_DEPTH];
   logic [s2d_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [s2d_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [s2d_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   s2d_pkg::mag_job_type                  new_job;
   logic                                  wr_en;
   logic                                  rd_en;

   always_comb begin
      new_job.neg = req_value[s2d_pkg::VALUE_W-1];
      new_job.mag = new_job.neg ? (s2d_pkg::VALUE_W'(0) - req_value) : req_value;
   end

   assign full      = (count_ff == s2d_pkg::QUEUE_CNT_W'(s2d_pkg::QUEUE_DEPTH));
   assign job_valid = (count_ff != '0);
   assign job       = q_ff[rd_ptr_ff];
   assign wr_en     = push && !full;
   assign rd_en     = job_take && job_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

// ===== src/s2d_conv.sv =====
// ---------------------------------------------------------------------------
// s2d_conv: binary-to-decimal converter
// Shift-and-add-3 conversion of a 32-bit magnitude into ten decimal digits,
// four bits per cycle, holding the result until the emitter takes it.
// ---------------------------------------------------------------------------
module s2d_conv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  s2d_pkg::mag_job_type  job,
   output logic                  job_take,
   output logic                  dec_valid,
   output s2d_pkg::dec_job_type  dec_job,
   input  logic                  dec_take
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;
   logic [s2d_pkg::STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [s2d_pkg::BCD_W-1:0]          bcd_ff, bcd_in;
   logic [s2d_pkg::VALUE_W-1:0]        bin_ff, bin_in;
   logic                               neg_ff, neg_in;
   logic [s2d_pkg::BCD_W-1:0]          bcd_step;
   logic [s2d_pkg::VALUE_W-1:0]        bin_step;
   logic                               free;

   always_comb begin
      bcd_step = bcd_ff;
      bin_step = bin_ff;
      for (int b = 0; b < s2d_pkg::BITS_PER_STEP; b++) begin
         for (int d = 0; d < s2d_pkg::DIGIT_CNT; d++) begin
            if (bcd_step[d*s2d_pkg::DIGIT_W +: s2d_pkg::DIGIT_W] >= s2d_pkg::DIGIT_W'(5)) begin
               bcd_step[d*s2d_pkg::DIGIT_W +: s2d_pkg::DIGIT_W] =
                  bcd_step[d*s2d_pkg::DIGIT_W +: s2d_pkg::DIGIT_W] + s2d_pkg::DIGIT_W'(3);
            end
         end
         bcd_step = {bcd_step[s2d_pkg::BCD_W-2:0], bin_step[s2d_pkg::VALUE_W-1]};
         bin_step = {bin_step[s2d_pkg::VALUE_W-2:0], 1'b0};
      end
   end

   assign free      = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && dec_take);
   assign job_take  = free && job_valid;
   assign dec_valid = (state_ff == ST_DONE);
   assign dec_job   = '{neg: neg_ff, digits: bcd_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bcd_in   = bcd_ff;
      bin_in   = bin_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         ST_IDLE, ST_DONE: begin
            if (free) begin
               state_in = ST_IDLE;
               if (job_valid) begin
                  state_in = ST_RUN;
                  cnt_in   = '0;
                  bcd_in   = '0;
                  bin_in   = job.mag;
                  neg_in   = job.neg;
               end
            end
         end
         ST_RUN: begin
            bcd_in = bcd_step;
            bin_in = bin_step;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == s2d_pkg::STEP_CNT_W'(s2d_pkg::STEP_CNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== src/s2d_emit.sv =====
// ---------------------------------------------------------------------------
// s2d_emit: character emitter
// Sends the sign and the significant digits of one converted number, one
// character per beat, through an output register.
// ---------------------------------------------------------------------------
module s2d_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        dec_valid,
   input  s2d_pkg::dec_job_type        dec_job,
   output logic                        dec_take,
   output logic [s2d_pkg::CHAR_W-1:0]  rsp_text_char,
   output logic                        rsp_last_char,
   output logic                        empty,
   input  logic                        pop
);

   logic                                busy_ff, busy_in;
   logic                                sign_ff, sign_in;
   logic [s2d_pkg::DIGIT_IDX_W-1:0]     idx_ff, idx_in;
   s2d_pkg::digit_type [s2d_pkg::DIGIT_CNT-1:0] digits_ff, digits_in;
   logic                                out_valid_ff, out_valid_in;
   logic [s2d_pkg::CHAR_W-1:0]          out_char_ff, out_char_in;
   logic                                out_last_ff, out_last_in;
   logic                                advance;
   logic                                produce;
   logic                                ending;
   logic [s2d_pkg::DIGIT_IDX_W-1:0]     top_idx;

   always_comb begin
      top_idx = '0;
      for (int d = 0; d < s2d_pkg::DIGIT_CNT; d++) begin
         if (dec_job.digits[d] != '0) begin
            top_idx = s2d_pkg::DIGIT_IDX_W'(d);
         end
      end
   end

   assign advance  = !out_valid_ff || pop;
   assign produce  = advance && busy_ff;
   assign ending   = produce && !sign_ff && (idx_ff == '0);
   assign dec_take = dec_valid && (!busy_ff || ending);

   always_comb begin
      busy_in      = busy_ff;
      sign_in      = sign_ff;
      idx_in       = idx_ff;
      digits_in    = digits_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = busy_ff;
      end
      if (produce) begin
         if (sign_ff) begin
            out_char_in = s2d_pkg::CHAR_MINUS;
            out_last_in = 1'b0;
            sign_in     = 1'b0;
         end else begin
            out_char_in = s2d_pkg::CHAR_ZERO + s2d_pkg::CHAR_W'(digits_ff[idx_ff]);
            out_last_in = (idx_ff == '0);
            idx_in      = idx_ff - 1'b1;
         end
      end
      if (ending) begin
         busy_in = 1'b0;
      end
      if (dec_take) begin
         busy_in   = 1'b1;
         sign_in   = dec_job.neg;
         idx_in    = top_idx;
         digits_in = dec_job.digits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      sign_ff     <= sign_in;
      idx_ff      <= idx_in;
      digits_ff   <= digits_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign empty         = !out_valid_ff;
   assign rsp_text_char = out_char_ff;
   assign rsp_last_char = out_last_ff;

endmodule

// ===== src/signed_int_to_decimal_ascii.sv =====
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Prints each integer as a run of characters, most significant first, with
// a leading minus sign for negative values and a flag on the last character.
//
//   Channel  Direction  Handshake     Beat contents
//   req      in         push / full   req_value (signed 32 bits)
//   rsp      out        pop / empty   rsp_text_char, rsp_last_char
//
// Within an item one character leaves per cycle while the output is not
// stalled. The converter works on the next item while the output still
// carries the previous one, so an item occupies the output for the length
// of its text, one to eleven characters; texts that are shorter than the
// conversion of the next item takes leave gaps between items.
// Reset clears the queue and all valid flags; a stalled output holds its beat
// and the converter and input queue keep filling behind it.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [s2d_pkg::VALUE_W-1:0] req_value,
   input  logic                               push,
   output logic                               full,
   output logic [s2d_pkg::CHAR_W-1:0]         rsp_text_char,
   output logic                               rsp_last_char,
   output logic                               empty,
   input  logic                               pop
);

   logic                  job_valid;
   logic                  job_take;
   s2d_pkg::mag_job_type  job;
   logic                  dec_valid;
   logic                  dec_take;
   s2d_pkg::dec_job_type  dec_job;

   s2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_value),
      .push      (push),
      .full      (full),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take)
   );

   s2d_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take),
      .dec_valid (dec_valid),
      .dec_job   (dec_job),
      .dec_take  (dec_take)
   );

   s2d_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .dec_valid     (dec_valid),
      .dec_job       (dec_job),
      .dec_take      (dec_take),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char),
      .empty         (empty),
      .pop           (pop)
   );

endmodule
